// ===== src/rsta_pkg.sv =====
// ----------------------------------------------------------------------------
// rsta_pkg
// Shared types, constants and the training byte map of the rank spacing
// timing adjust block.
// ----------------------------------------------------------------------------
package rsta_pkg;

    // Store sizes
    localparam int FREQ_POINTS = 4;
    localparam int TRAIN_WORDS = 33;
    localparam int ADDR_W      = $clog2(TRAIN_WORDS);
    localparam int FP_IDX_W    = (FREQ_POINTS > 1) ? $clog2(FREQ_POINTS) : 1;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LPDDR4  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VARIANT = 1'b1;

    // SoC variant codes
    localparam logic [1:0] VAR_GAP_POINT0 = 2'd0;
    localparam logic [1:0] VAR_NO_PLUS    = 2'd1;
    localparam logic [1:0] VAR_DEFAULT    = 2'd2;

    // Command codes
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_CLOSE  = 2'd1;
    localparam logic [1:0] CMD_ADJUST = 2'd2;

    // Register masks and saturation limits
    localparam logic [31:0] TURN_LP_MASK   = 32'hffffc0c0;
    localparam logic [31:0] TURN_DDR4_MASK = 32'hffffc0ff;
    localparam logic [31:0] W2R_DDR4_MASK  = 32'hffffffc0;
    localparam logic [31:0] GAP_MASK       = 32'hfffff00f;
    localparam logic [5:0]  TURN_SAT       = 6'h3f;
    localparam logic [3:0]  GAP_SAT        = 4'hf;

    // Delay groups
    typedef enum logic [2:0] {
        GRP_RR,
        GRP_RW,
        GRP_WR,
        GRP_WW,
        GRP_NONE
    } grp_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_STORE
    } st_t;

    // Controller to datapath commands
    typedef struct packed {
        logic mem_we;
        logic close_start;
        logic walk;
        logic store;
        logic out_load;
    } rsta_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last_addr;
    } rsta_stat_t;

    // Group of the low (hi = 0) or high (hi = 1) delay byte of a training word
    function automatic grp_t byte_group(input logic lp, input logic [5:0] w, input logic hi);
        logic [6:0] k;
        grp_t       g;
        k = {w, hi};
        g = GRP_NONE;
        if (lp) begin
            case (w)
                6'd1:       g = hi ? GRP_RR : GRP_NONE;
                6'd2, 6'd3: g = GRP_RW;
                6'd4, 6'd5: g = GRP_WR;
                6'd6:       g = hi ? GRP_NONE : GRP_WW;
                6'd26:      g = hi ? GRP_RR : GRP_NONE;
                6'd27:      g = hi ? GRP_RW : GRP_RR;
                6'd28:      g = GRP_RW;
                6'd29:      g = hi ? GRP_WR : GRP_RW;
                6'd30:      g = GRP_WR;
                6'd31:      g = hi ? GRP_WW : GRP_WR;
                6'd32:      g = hi ? GRP_NONE : GRP_WW;
                default:    g = GRP_NONE;
            endcase
        end else begin
            if (k >= 7'd1 && k <= 7'd12) begin
                g = GRP_RR;
            end else if (k >= 7'd13 && k <= 7'd24) begin
                g = GRP_WW;
            end else if (k >= 7'd25 && k <= 7'd40) begin
                g = GRP_RW;
            end else if (k >= 7'd41 && k <= 7'd56) begin
                g = GRP_WR;
            end
        end
        return g;
    endfunction

endpackage

// ===== src/rsta_ctrl.sv =====
// ----------------------------------------------------------------------------
// rsta_ctrl
// Sequencer: takes input beats, runs the word walk of a close command and
// owns the result beat's valid flag.
// ----------------------------------------------------------------------------
module rsta_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_cmd,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  rsta_pkg::rsta_stat_t  stat,
    output rsta_pkg::rsta_cmd_t   cmd
);

    rsta_pkg::st_t state_reg, state_next;
    logic          m_valid_reg, m_valid_next;
    logic          out_free;
    logic          accept;

    // State and result flag registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rsta_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        out_free   = !m_valid_reg || m_ready;
        s_ready    = 1'b0;
        accept     = 1'b0;
        case (state_reg)
            rsta_pkg::ST_IDLE: begin
                s_ready = (s_cmd != rsta_pkg::CMD_ADJUST) || out_free;
                accept  = s_valid && s_ready;
                if (accept) begin
                    case (s_cmd)
                        rsta_pkg::CMD_LOAD:   cmd.mem_we = 1'b1;
                        rsta_pkg::CMD_CLOSE: begin
                            cmd.close_start = 1'b1;
                            state_next      = rsta_pkg::ST_WALK;
                        end
                        rsta_pkg::CMD_ADJUST: cmd.out_load = 1'b1;
                        default: ;
                    endcase
                end
            end
            rsta_pkg::ST_WALK: begin
                cmd.walk = 1'b1;
                if (stat.last_addr) begin
                    state_next = rsta_pkg::ST_DRAIN;
                end
            end
            rsta_pkg::ST_DRAIN: begin
                state_next = rsta_pkg::ST_STORE;
            end
            rsta_pkg::ST_STORE: begin
                cmd.store  = 1'b1;
                state_next = rsta_pkg::ST_IDLE;
            end
            default: begin
                state_next = rsta_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold the result beat until taken
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

    // Assertions
    a_close_walks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_cmd == rsta_pkg::CMD_CLOSE) |=> state_reg == rsta_pkg::ST_WALK)
        else $error("close beat did not start the word walk");

    a_store_once: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rsta_pkg::ST_STORE |=> state_reg == rsta_pkg::ST_IDLE)
        else $error("maxima store lasted more than one cycle");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result beat overwritten before it was taken");

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != rsta_pkg::ST_IDLE) |-> !s_ready && !cmd.out_load && !cmd.mem_we)
        else $error("input taken during the word walk");

endmodule

// ===== src/rsta_dpath.sv =====
// ----------------------------------------------------------------------------
// rsta_dpath
// Datapath: configuration registers, training word store, group maxima
// accumulation and the timing field adjust with its result registers.
// ----------------------------------------------------------------------------
module rsta_dpath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [rsta_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rsta_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [1:0]                          s_freq_point,
    input  logic [5:0]                          s_word_index,
    input  logic [15:0]                         s_word_data,
    input  logic [31:0]                         s_turnaround_in,
    input  logic [31:0]                         s_ddr4_w2r_in,
    input  logic [31:0]                         s_rank_gap_in,
    output logic [31:0]                         m_turnaround_out,
    output logic [31:0]                         m_ddr4_w2r_out,
    output logic [31:0]                         m_rank_gap_out,
    input  rsta_pkg::rsta_cmd_t                 cmd,
    output rsta_pkg::rsta_stat_t                stat
);

    // Widen a turnaround field by half the maximum, saturating
    function automatic logic [5:0] widen_turn(input logic [5:0] f, input logic [6:0] mx,
                                              input logic plus);
        logic [6:0] t;
        t = {1'b0, f} + {1'b0, mx[6:1]} + {6'd0, plus};
        return (t > {1'b0, rsta_pkg::TURN_SAT}) ? rsta_pkg::TURN_SAT : t[5:0];
    endfunction

    // Widen a rank gap field by half the maximum, saturating
    function automatic logic [3:0] widen_gap(input logic [3:0] f, input logic [6:0] mx,
                                             input logic plus);
        logic [6:0] t;
        t = {3'd0, f} + {1'b0, mx[6:1]} + {6'd0, plus};
        return (t > {3'd0, rsta_pkg::GAP_SAT}) ? rsta_pkg::GAP_SAT : t[3:0];
    endfunction

    logic                           lp_reg;
    logic [1:0]                     var_reg;
    logic [15:0]                    words_mem [rsta_pkg::TRAIN_WORDS];
    logic [15:0]                    rd_data_reg;
    logic [rsta_pkg::ADDR_W-1:0]    cnt_reg;
    logic [rsta_pkg::ADDR_W-1:0]    rd_word_reg;
    logic                           rd_vld_reg;
    logic [1:0]                     fp_reg;
    logic [6:0]                     run_reg  [4];
    logic [6:0]                     run_next [4];
    logic [6:0]                     gm_reg   [rsta_pkg::FREQ_POINTS][4];
    logic [6:0]                     mx       [4];
    logic [31:0]                    turn_reg, d4w_reg, gap_reg;
    logic [31:0]                    turn_next, d4w_next, gap_next;
    logic [3:0]                     fp_ext, fpr_ext;
    logic                           fp_ok, fpr_ok;
    logic                           wr_ok;
    logic                           plus;
    logic [5:0]                     rd_word6;
    rsta_pkg::grp_t                 g_lo, g_hi;
    logic [5:0]                     w2r, r2w;
    logic [3:0]                     wrg, rdg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lp_reg  <= 1'b0;
            var_reg <= rsta_pkg::VAR_DEFAULT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rsta_pkg::CFG_LPDDR4:  lp_reg  <= cfg_wdata[0];
                rsta_pkg::CFG_VARIANT: var_reg <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Training word store: one write port, one registered read port
    assign wr_ok = {1'b0, s_word_index} < 7'(rsta_pkg::TRAIN_WORDS);

    always_ff @(posedge aclk) begin
        if (cmd.mem_we && wr_ok) begin
            words_mem[s_word_index[rsta_pkg::ADDR_W-1:0]] <= s_word_data;
        end
        rd_data_reg <= words_mem[cnt_reg];
    end

    // Walk address counter and read tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (cmd.close_start) begin
                cnt_reg <= '0;
            end else if (cmd.walk) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            rd_vld_reg <= cmd.walk;
        end
    end

    always_ff @(posedge aclk) begin
        rd_word_reg <= cnt_reg;
        if (cmd.close_start) begin
            fp_reg <= s_freq_point;
        end
    end

    assign stat.last_addr = (cnt_reg == rsta_pkg::ADDR_W'(rsta_pkg::TRAIN_WORDS - 1));

    // Fold both delay bytes of the read word into the running maxima
    assign rd_word6 = 6'(rd_word_reg);
    assign g_lo     = rsta_pkg::byte_group(lp_reg, rd_word6, 1'b0);
    assign g_hi     = rsta_pkg::byte_group(lp_reg, rd_word6, 1'b1);

    always_comb begin
        for (int g = 0; g < 4; g++) begin
            run_next[g] = run_reg[g];
            if (rd_vld_reg) begin
                if (g_lo == rsta_pkg::grp_t'(g) && !rd_data_reg[7]
                    && rd_data_reg[6:0] > run_next[g]) begin
                    run_next[g] = rd_data_reg[6:0];
                end
                if (g_hi == rsta_pkg::grp_t'(g) && !rd_data_reg[15]
                    && rd_data_reg[14:8] > run_next[g]) begin
                    run_next[g] = rd_data_reg[14:8];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int g = 0; g < 4; g++) begin
            if (cmd.close_start) begin
                run_reg[g] <= '0;
            end else begin
                run_reg[g] <= run_next[g];
            end
        end
    end

    // Group maxima per frequency point
    assign fpr_ext = {2'b0, fp_reg};
    assign fpr_ok  = fpr_ext < 4'(rsta_pkg::FREQ_POINTS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < rsta_pkg::FREQ_POINTS; p++) begin
                for (int g = 0; g < 4; g++) begin
                    gm_reg[p][g] <= '0;
                end
            end
        end else if (cmd.store && fpr_ok) begin
            for (int g = 0; g < 4; g++) begin
                gm_reg[fpr_ext[rsta_pkg::FP_IDX_W-1:0]][g] <= run_reg[g];
            end
        end
    end

    // Adjust the timing fields of the requested point
    assign fp_ext = {2'b0, s_freq_point};
    assign fp_ok  = fp_ext < 4'(rsta_pkg::FREQ_POINTS);
    assign plus   = (var_reg != rsta_pkg::VAR_NO_PLUS);

    always_comb begin
        for (int g = 0; g < 4; g++) begin
            mx[g] = fp_ok ? gm_reg[fp_ext[rsta_pkg::FP_IDX_W-1:0]][g] : 7'd0;
        end
    end

    always_comb begin
        turn_next = s_turnaround_in;
        d4w_next  = s_ddr4_w2r_in;
        gap_next  = s_rank_gap_in;
        r2w       = widen_turn(s_turnaround_in[13:8], mx[2'(rsta_pkg::GRP_RW)], plus);
        wrg       = widen_gap(s_rank_gap_in[11:8], mx[2'(rsta_pkg::GRP_WW)], plus);
        rdg       = widen_gap(s_rank_gap_in[7:4], mx[2'(rsta_pkg::GRP_RR)], plus);
        if (lp_reg) begin
            w2r       = widen_turn(s_turnaround_in[5:0], mx[2'(rsta_pkg::GRP_WR)], plus);
            turn_next = (s_turnaround_in & rsta_pkg::TURN_LP_MASK)
                      | {18'd0, r2w, 2'd0, w2r};
        end else begin
            w2r       = widen_turn(s_ddr4_w2r_in[5:0], mx[2'(rsta_pkg::GRP_WR)], plus);
            d4w_next  = (s_ddr4_w2r_in & rsta_pkg::W2R_DDR4_MASK) | {26'd0, w2r};
            turn_next = (s_turnaround_in & rsta_pkg::TURN_DDR4_MASK) | {18'd0, r2w, 8'd0};
        end
        if (var_reg != rsta_pkg::VAR_GAP_POINT0 || s_freq_point == 2'd0) begin
            gap_next = (s_rank_gap_in & rsta_pkg::GAP_MASK) | {20'd0, wrg, rdg, 4'd0};
        end
    end

    // Result registers
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            turn_reg <= turn_next;
            d4w_reg  <= d4w_next;
            gap_reg  <= gap_next;
        end
    end

    assign m_turnaround_out = turn_reg;
    assign m_ddr4_w2r_out   = d4w_reg;
    assign m_rank_gap_out   = gap_reg;

endmodule

// ===== src/rank_spacing_timing_adjust.sv =====
// ----------------------------------------------------------------------------
// rank_spacing_timing_adjust
// Widens rank-to-rank turnaround timings from stored PHY training delays.
// ----------------------------------------------------------------------------
// A load beat stores one training word; an adjust beat puts the adjusted
// registers into an output register, where they wait, and further loads
// and closes are taken while they wait. A close beat walks the whole
// training word store through its single read port, one word a cycle, and
// keeps the block busy through its walk, drain and store states after it
// is accepted, before the next beat is taken. Configuration writes must be
// made only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module rank_spacing_timing_adjust (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [rsta_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rsta_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_cmd,
    input  logic [1:0]                      s_freq_point,
    input  logic [5:0]                      s_word_index,
    input  logic [15:0]                     s_word_data,
    input  logic [31:0]                     s_turnaround_in,
    input  logic [31:0]                     s_ddr4_w2r_in,
    input  logic [31:0]                     s_rank_gap_in,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [31:0]                     m_turnaround_out,
    output logic [31:0]                     m_ddr4_w2r_out,
    output logic [31:0]                     m_rank_gap_out
);

    rsta_pkg::rsta_cmd_t  cmd;
    rsta_pkg::rsta_stat_t stat;

    // Sequencer
    rsta_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath
    rsta_dpath u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_freq_point     (s_freq_point),
        .s_word_index     (s_word_index),
        .s_word_data      (s_word_data),
        .s_turnaround_in  (s_turnaround_in),
        .s_ddr4_w2r_in    (s_ddr4_w2r_in),
        .s_rank_gap_in    (s_rank_gap_in),
        .m_turnaround_out (m_turnaround_out),
        .m_ddr4_w2r_out   (m_ddr4_w2r_out),
        .m_rank_gap_out   (m_rank_gap_out),
        .cmd              (cmd),
        .stat             (stat)
    );

endmodule

// ===== verif/rank_spacing_timing_adjust_tb.sv =====
// ----------------------------------------------------------------------------
// rank_spacing_timing_adjust_tb
// Drives load, close and adjust beats into the rank spacing adjust block under
// several DRAM type and SoC variant settings, predicts every adjusted register
// set from an independent model of the delay store and group maxima, and
// compares each result beat field by field. Both channels idle and stall at
// random, with one long output stall and one full drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rank_spacing_timing_adjust_tb;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          SETTLE_CYCLES = 48;
    localparam int          STALL_CYCLES = 300;
    localparam logic [1:0]  CMD_NONE     = 2'd3;
    localparam logic [1:0]  VAR_UNKNOWN  = 2'd3;

    typedef struct {
        logic [1:0]  cmd;
        logic [1:0]  freq_point;
        logic [5:0]  word_index;
        logic [15:0] word_data;
        logic [31:0] turnaround_in;
        logic [31:0] ddr4_w2r_in;
        logic [31:0] rank_gap_in;
    } cmd_beat_t;

    typedef struct {
        logic [31:0] turnaround;
        logic [31:0] ddr4_w2r;
        logic [31:0] rank_gap;
    } timing_regs_t;

    logic                            aclk             = 1'b0;
    logic                            aresetn          = 1'b0;
    logic                            cfg_wr_en        = 1'b0;
    logic [rsta_pkg::CFG_IDX_W-1:0]  cfg_index        = '0;
    logic [rsta_pkg::CFG_DATA_W-1:0] cfg_wdata        = '0;
    logic                            s_valid          = 1'b0;
    logic                            s_ready;
    logic [1:0]                      s_cmd            = '0;
    logic [1:0]                      s_freq_point     = '0;
    logic [5:0]                      s_word_index     = '0;
    logic [15:0]                     s_word_data      = '0;
    logic [31:0]                     s_turnaround_in  = '0;
    logic [31:0]                     s_ddr4_w2r_in    = '0;
    logic [31:0]                     s_rank_gap_in    = '0;
    logic                            m_valid;
    logic                            m_ready          = 1'b0;
    logic [31:0]                     m_turnaround_out;
    logic [31:0]                     m_ddr4_w2r_out;
    logic [31:0]                     m_rank_gap_out;

    // Predicted block state and configuration
    logic [15:0]  train_words [rsta_pkg::TRAIN_WORDS];
    logic [6:0]   point_max [rsta_pkg::FREQ_POINTS][4];
    logic         cur_lpddr4  = 1'b0;
    logic [1:0]   cur_variant = rsta_pkg::VAR_DEFAULT;
    timing_regs_t expected_timings [$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  quiet          = 1'b0;
    int  stall_request  = 0;
    int  stall_served   = 0;
    int  stall_left     = 0;

    rank_spacing_timing_adjust dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_freq_point     (s_freq_point),
        .s_word_index     (s_word_index),
        .s_word_data      (s_word_data),
        .s_turnaround_in  (s_turnaround_in),
        .s_ddr4_w2r_in    (s_ddr4_w2r_in),
        .s_rank_gap_in    (s_rank_gap_in),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_turnaround_out (m_turnaround_out),
        .m_ddr4_w2r_out   (m_ddr4_w2r_out),
        .m_rank_gap_out   (m_rank_gap_out)
    );

    always #5 aclk = ~aclk;

    // Bound the run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Keep the larger delay, ignoring bytes with bit 7 set
    function automatic logic [6:0] fold_delay(logic [6:0] cur, logic [7:0] b);
        if (!b[7] && b[6:0] > cur) return b[6:0];
        return cur;
    endfunction

    function automatic int widen_field(int field, int mx, int plus, int sat);
        int t;
        t = field + (mx >> 1) + plus;
        return (t > sat) ? sat : t;
    endfunction

    // Split the stored words into delay bytes and keep each group's maximum
    task automatic collect_point_maxima(logic [1:0] fp);
        logic [7:0] cha [12];
        logic [7:0] chb [12];
        logic [7:0] flat [58];
        logic [6:0] mx [4];
        int         g;
        for (int k = 0; k < 4; k++) mx[k] = '0;
        if (cur_lpddr4) begin
            for (int i = 0; i < 12; i++) chb[i] = 8'h00;
            for (int i = 0; i < 6; i++) begin
                cha[i * 2]     = train_words[1 + i][7:0];
                cha[i * 2 + 1] = train_words[1 + i][15:8];
            end
            // Channel A byte 0 and byte 11 come from the channel B words
            cha[0]  = train_words[26][15:8];
            cha[11] = train_words[32][7:0];
            for (int i = 1; i < 6; i++) begin
                chb[i * 2 - 1] = train_words[26 + i][7:0];
                chb[i * 2]     = train_words[26 + i][15:8];
            end
            for (int i = 0; i < 12; i++) begin
                if (i < 2) g = rsta_pkg::GRP_RR;
                else if (i < 6) g = rsta_pkg::GRP_RW;
                else if (i < 10) g = rsta_pkg::GRP_WR;
                else g = rsta_pkg::GRP_WW;
                mx[g] = fold_delay(fold_delay(mx[g], cha[i]), chb[i]);
            end
        end else begin
            for (int i = 0; i < 29; i++) begin
                flat[i * 2]     = train_words[i][7:0];
                flat[i * 2 + 1] = train_words[i][15:8];
            end
            for (int i = 1; i <= 56; i++) begin
                if (i <= 12) g = rsta_pkg::GRP_RR;
                else if (i <= 24) g = rsta_pkg::GRP_WW;
                else if (i <= 40) g = rsta_pkg::GRP_RW;
                else g = rsta_pkg::GRP_WR;
                mx[g] = fold_delay(mx[g], flat[i]);
            end
        end
        if (fp < rsta_pkg::FREQ_POINTS) begin
            for (int k = 0; k < 4; k++) point_max[fp][k] = mx[k];
        end
    endtask

    function automatic timing_regs_t adjust_registers(cmd_beat_t b);
        timing_regs_t r;
        int           plus, w2r, r2w, wrg, rdg;
        int           m_rr, m_rw, m_wr, m_ww;
        int           turn_sat, gap_sat;
        plus = (cur_variant == rsta_pkg::VAR_NO_PLUS) ? 0 : 1;
        turn_sat = int'(rsta_pkg::TURN_SAT);
        gap_sat  = int'(rsta_pkg::GAP_SAT);
        m_rr = 0; m_rw = 0; m_wr = 0; m_ww = 0;
        if (b.freq_point < rsta_pkg::FREQ_POINTS) begin
            m_rr = int'(point_max[b.freq_point][2'(rsta_pkg::GRP_RR)]);
            m_rw = int'(point_max[b.freq_point][2'(rsta_pkg::GRP_RW)]);
            m_wr = int'(point_max[b.freq_point][2'(rsta_pkg::GRP_WR)]);
            m_ww = int'(point_max[b.freq_point][2'(rsta_pkg::GRP_WW)]);
        end
        r.turnaround = b.turnaround_in;
        r.ddr4_w2r   = b.ddr4_w2r_in;
        r.rank_gap   = b.rank_gap_in;
        r2w = widen_field(int'(b.turnaround_in[13:8]), m_rw, plus, turn_sat);
        if (cur_lpddr4) begin
            w2r = widen_field(int'(b.turnaround_in[5:0]), m_wr, plus, turn_sat);
            r.turnaround = (b.turnaround_in & rsta_pkg::TURN_LP_MASK)
                         | (32'(r2w) << 8) | 32'(w2r);
        end else begin
            w2r = widen_field(int'(b.ddr4_w2r_in[5:0]), m_wr, plus, turn_sat);
            r.ddr4_w2r   = (b.ddr4_w2r_in & rsta_pkg::W2R_DDR4_MASK) | 32'(w2r);
            r.turnaround = (b.turnaround_in & rsta_pkg::TURN_DDR4_MASK) | (32'(r2w) << 8);
        end
        // Rank gaps: on the point-0-only variant, leave other points alone
        if (cur_variant != rsta_pkg::VAR_GAP_POINT0 || b.freq_point == 2'd0) begin
            wrg = widen_field(int'(b.rank_gap_in[11:8]), m_ww, plus, gap_sat);
            rdg = widen_field(int'(b.rank_gap_in[7:4]), m_rr, plus, gap_sat);
            r.rank_gap = (b.rank_gap_in & rsta_pkg::GAP_MASK)
                       | (32'(wrg) << 8) | (32'(rdg) << 4);
        end
        return r;
    endfunction

    task automatic apply_beat(cmd_beat_t b);
        case (b.cmd)
            rsta_pkg::CMD_LOAD: begin
                if (b.word_index < rsta_pkg::TRAIN_WORDS)
                    train_words[b.word_index] = b.word_data;
            end
            rsta_pkg::CMD_CLOSE:  collect_point_maxima(b.freq_point);
            rsta_pkg::CMD_ADJUST: expected_timings.push_back(adjust_registers(b));
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("[%0t] MISMATCH %s", $realtime, what);
    endtask

    // Hold off on request, otherwise stall at random
    always @(posedge aclk) begin
        if (stall_request != stall_served) begin
            stall_served = stall_request;
            stall_left   = STALL_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet || ($urandom_range(0, 99) >= 28);
        end
    end

    // Compare each result beat with the oldest prediction
    always @(posedge aclk) begin : check_results
        timing_regs_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_timings.size() == 0) begin
                report_mismatch($sformatf("result beat with none expected: %h %h %h",
                    m_turnaround_out, m_ddr4_w2r_out, m_rank_gap_out));
            end else begin
                want = expected_timings.pop_front();
                if (m_turnaround_out !== want.turnaround)
                    report_mismatch($sformatf("turnaround_out %h, want %h",
                        m_turnaround_out, want.turnaround));
                if (m_ddr4_w2r_out !== want.ddr4_w2r)
                    report_mismatch($sformatf("ddr4_w2r_out %h, want %h",
                        m_ddr4_w2r_out, want.ddr4_w2r));
                if (m_rank_gap_out !== want.rank_gap)
                    report_mismatch($sformatf("rank_gap_out %h, want %h",
                        m_rank_gap_out, want.rank_gap));
            end
        end
    end

    // ------------------------------------------------------------------
    // Beat builders and driver
    // ------------------------------------------------------------------

    function automatic cmd_beat_t noise_beat();
        cmd_beat_t b;
        b.cmd           = 2'($urandom);
        b.freq_point    = 2'($urandom);
        b.word_index    = 6'($urandom);
        b.word_data     = 16'($urandom);
        b.turnaround_in = $urandom;
        b.ddr4_w2r_in   = $urandom;
        b.rank_gap_in   = $urandom;
        return b;
    endfunction

    function automatic cmd_beat_t load_beat(int idx, logic [15:0] data);
        cmd_beat_t b;
        b = noise_beat();
        b.cmd        = rsta_pkg::CMD_LOAD;
        b.word_index = 6'(idx);
        b.word_data  = data;
        return b;
    endfunction

    function automatic cmd_beat_t close_beat(logic [1:0] fp);
        cmd_beat_t b;
        b = noise_beat();
        b.cmd        = rsta_pkg::CMD_CLOSE;
        b.freq_point = fp;
        return b;
    endfunction

    function automatic cmd_beat_t adjust_beat(logic [1:0] fp, logic [31:0] t,
                                              logic [31:0] w, logic [31:0] g);
        cmd_beat_t b;
        b = noise_beat();
        b.cmd           = rsta_pkg::CMD_ADJUST;
        b.freq_point    = fp;
        b.turnaround_in = t;
        b.ddr4_w2r_in   = w;
        b.rank_gap_in   = g;
        return b;
    endfunction

    // Delay byte up to a ceiling, now and then with bit 7 set
    function automatic logic [7:0] rand_delay(int lim);
        if ($urandom_range(0, 3) == 0) return {1'b1, 7'($urandom)};
        return 8'($urandom_range(0, lim));
    endfunction

    // Register value, often with small timing fields
    function automatic logic [31:0] rand_reg();
        if ($urandom_range(0, 1) == 0) return $urandom & 32'hffffc3c3;
        return $urandom;
    endfunction

    // Offer one beat and hold it until taken
    task automatic send_beat(cmd_beat_t b);
        while (!quiet && $urandom_range(0, 99) < 28) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_cmd           <= b.cmd;
        s_freq_point    <= b.freq_point;
        s_word_index    <= b.word_index;
        s_word_data     <= b.word_data;
        s_turnaround_in <= b.turnaround_in;
        s_ddr4_w2r_in   <= b.ddr4_w2r_in;
        s_rank_gap_in   <= b.rank_gap_in;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_beat(b);
    endtask

    task automatic wait_results();
        while (expected_timings.size() != 0) @(posedge aclk);
    endtask

    // Reprogram only once the block has gone idle
    task automatic set_mode(logic lp, logic [1:0] variant);
        s_valid <= 1'b0;
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= rsta_pkg::CFG_LPDDR4;
        cfg_wdata <= {1'b0, lp};
        @(posedge aclk);
        cur_lpddr4 = lp;
        cfg_index <= rsta_pkg::CFG_VARIANT;
        cfg_wdata <= variant;
        @(posedge aclk);
        cur_variant = variant;
        cfg_wr_en <= 1'b0;
    endtask

    // One well-formed load/close/adjust sequence, or a single noise beat
    task automatic send_sequence(output int sent);
        int         lim;
        logic [1:0] fp;
        sent = 0;
        if ($urandom_range(0, 99) < 80) begin
            case ($urandom_range(0, 2))
                0:       lim = $urandom_range(0, 15);
                1:       lim = $urandom_range(0, 40);
                default: lim = $urandom_range(0, 127);
            endcase
            repeat ($urandom_range(2, 10)) begin
                send_beat(load_beat($urandom_range(0, rsta_pkg::TRAIN_WORDS - 1),
                                    {rand_delay(lim), rand_delay(lim)}));
                sent++;
            end
            fp = 2'($urandom);
            send_beat(close_beat(fp));
            sent++;
            repeat ($urandom_range(1, 4)) begin
                send_beat(adjust_beat(($urandom_range(0, 9) < 7) ? fp : 2'($urandom),
                                      rand_reg(), rand_reg(), rand_reg()));
                sent++;
            end
        end else begin
            send_beat(noise_beat());
            sent = 1;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Write every training word so that no close reads an unwritten one
    task automatic test_fill_store();
        logic [15:0] data;
        for (int i = 0; i < rsta_pkg::TRAIN_WORDS; i++) begin
            case (i)
                0:       data = 16'h0000;
                1:       data = 16'hffff;
                2:       data = 16'h7f7f;
                3:       data = 16'h8080;
                default: data = {rand_delay(40), rand_delay(40)};
            endcase
            send_beat(load_beat(i, data));
        end
    endtask

    task automatic test_directed_ddr4();
        cmd_beat_t b;
        // Adjust with all maxima still zero
        send_beat(adjust_beat(2'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
        send_beat(adjust_beat(2'd1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        // Loads beyond the store are dropped
        send_beat(load_beat(63, 16'hffff));
        send_beat(load_beat(rsta_pkg::TRAIN_WORDS, 16'h1234));
        b = noise_beat();
        b.cmd = CMD_NONE;
        send_beat(b);
        // Largest legal delay, bit 7 set ignored, bytes outside every group
        send_beat(load_beat(1, 16'h7f7f));
        send_beat(load_beat(10, 16'h8080));
        send_beat(load_beat(0, 16'h00ff));
        send_beat(load_beat(28, 16'hff7f));
        send_beat(close_beat(2'd0));
        send_beat(close_beat(2'd3));
        send_beat(adjust_beat(2'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
        send_beat(adjust_beat(2'd3, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        send_beat(adjust_beat(2'd2, 32'h0000_3f3f, 32'h0000_003f, 32'h0000_0ff0));
        send_beat(close_beat(2'd1));
        send_beat(adjust_beat(2'd1, 32'h0000_0000, 32'hffff_ffc0, 32'hffff_f00f));
    endtask

    // LPDDR4 map: channel A bytes taken from the channel B words
    task automatic test_directed_lpddr4();
        send_beat(load_beat(26, 16'h7e00));
        send_beat(load_beat(32, 16'h807d));
        send_beat(load_beat(27, 16'h7c80));
        send_beat(close_beat(2'd2));
        send_beat(adjust_beat(2'd2, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000));
        send_beat(close_beat(2'd0));
        send_beat(adjust_beat(2'd0, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff));
        send_beat(adjust_beat(2'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    endtask

    task automatic test_random_traffic(int n);
        int total, k;
        total = 0;
        while (total < n) begin
            send_sequence(k);
            total += k;
        end
    endtask

    // Long output stall while adjust beats keep coming
    task automatic test_output_backpressure();
        stall_request++;
        repeat (6) begin
            send_beat(adjust_beat(2'($urandom), rand_reg(), rand_reg(), rand_reg()));
            send_beat(load_beat($urandom_range(0, rsta_pkg::TRAIN_WORDS - 1),
                                16'($urandom)));
        end
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_streaming(int n);
        quiet = 1'b1;
        test_random_traffic(n);
        quiet = 1'b0;
    endtask

    // Stop sending until every result has come back, then resume
    task automatic test_drain_pause(int n);
        test_random_traffic(n / 2);
        s_valid <= 1'b0;
        wait_results();
        @(posedge aclk);
        test_random_traffic(n - n / 2);
    endtask

    initial begin
        for (int i = 0; i < rsta_pkg::TRAIN_WORDS; i++) train_words[i] = '0;
        for (int p = 0; p < rsta_pkg::FREQ_POINTS; p++)
            for (int k = 0; k < 4; k++) point_max[p][k] = '0;

        // Hold reset, then release
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_fill_store();
        test_directed_ddr4();
        test_random_traffic(80);

        set_mode(1'b1, rsta_pkg::VAR_GAP_POINT0);
        test_directed_lpddr4();
        test_random_traffic(80);
        test_output_backpressure();

        set_mode(1'b0, rsta_pkg::VAR_NO_PLUS);
        test_streaming(100);

        set_mode(1'b1, VAR_UNKNOWN);
        test_drain_pause(90);

        set_mode(1'b0, rsta_pkg::VAR_GAP_POINT0);
        test_random_traffic(80);

        set_mode(1'b1, rsta_pkg::VAR_NO_PLUS);
        test_random_traffic(60);

        // Let everything drain
        s_valid <= 1'b0;
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/rsta_pkg.sv
src/rsta_ctrl.sv
src/rsta_dpath.sv
src/rank_spacing_timing_adjust.sv
verif/rank_spacing_timing_adjust_tb.sv
